// ===== src/assert_macros.svh =====
// Assertion macros shared by the envelope allpass chain RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define EMAC_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define EMAC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/emac_pkg.sv =====
// Package: constants, tables and helpers of the envelope allpass chain.
`timescale 1ns / 1ps
package emac_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int MAX_STAGES   = 16;
    localparam int STG_W        = $clog2(MAX_STAGES);
    localparam int DLY_AW       = 13;
    localparam int DELAY_DEPTH  = 1 << DLY_AW;
    localparam int POS_W        = DLY_AW + 16;
    localparam int AP_AW        = 1 + STG_W + DLY_AW;
    localparam int AP_DEPTH     = 1 << AP_AW;
    localparam int PTR_COUNT    = 2 * MAX_STAGES;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_MS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHATTER_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_PERCENT    = 3'd5;

    localparam logic [31:0] GAIN_Q16  = 32'd39322;
    localparam logic [31:0] MIX_RECIP = 32'd1374389535;
    localparam int          MIX_SHIFT = 37;
    localparam logic [6:0]  MIX_FULL  = 7'd100;

    localparam logic [POS_W-1:0] DLY_MIN = POS_W'(1) << 16;
    localparam logic [POS_W-1:0] DLY_MAX = POS_W'(DELAY_DEPTH - 1) << 16;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [20:0] t_base_tab [MAX_STAGES];

    function automatic t_base_tab base_table();
        t_base_tab t;
        for (int i = 0; i < MAX_STAGES; i++) begin
            t[i] = 21'(((11 + 7 * i) * 65536 + 5) / 10);
        end
        return t;
    endfunction

    localparam t_base_tab BASE_MS = base_table();

    function automatic t_sample sat_sample(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
        lo = -(64'sd1 <<< (SAMPLE_BITS - 1));
        if (v > hi) return t_sample'(hi);
        if (v < lo) return t_sample'(lo);
        return t_sample'(v);
    endfunction

endpackage

// ===== src/emac_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module emac_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== src/envelope_modulated_allpass_chain.sv =====
// Top level: envelope-modulated allpass cascade with Haas delay and dry/wet mix.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One sample enters per transaction and leaves as one mixed sample. A single
// 32x32 multiplier and one single-port delay RAM are shared by all stages under
// a sequencer, so no new input is taken until the result of the last one is in
// the output register; channel 1 also runs a Haas delay pass. After reset a
// clearing pass zeroes the delay memories before the first input.
module envelope_modulated_allpass_chain
    import emac_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [23:0] sample_in
    input  logic [0:0]            s_axis_tuser,   // [0] channel_number
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [23:0] sample_out
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_E1  = 5'd2,  S_E2  = 5'd3;
    localparam logic [4:0] S_E3   = 5'd4,  S_B1   = 5'd5,  S_B2  = 5'd6,  S_D1  = 5'd7;
    localparam logic [4:0] S_D2   = 5'd8,  S_RD1  = 5'd9,  S_RD2 = 5'd10, S_RD3 = 5'd11;
    localparam logic [4:0] S_I2   = 5'd12, S_I3   = 5'd13, S_A1  = 5'd14, S_A2  = 5'd15;
    localparam logic [4:0] S_A3   = 5'd16, S_H1   = 5'd17, S_H2  = 5'd18, S_M1  = 5'd19;
    localparam logic [4:0] S_M2   = 5'd20, S_M3   = 5'd21, S_M4  = 5'd22, S_M5  = 5'd23;

    // configuration
    logic [4:0]  r_stage_count;
    logic [23:0] r_attack_coeff;
    logic [23:0] r_release_coeff;
    logic [15:0] r_samples_per_ms;
    logic [14:0] r_shatter_ms;
    logic [6:0]  r_mix_percent;

    // control
    logic [4:0]        r_state;
    logic [4:0]        n_state;
    logic [AP_AW-1:0]  r_clr_cnt;
    logic              r_clr_done;
    logic [STG_W-1:0]  r_stage;
    logic [STG_W-1:0]  r_last;
    logic              r_haas;
    logic              r_ch;
    logic              r_out_valid;
    logic [23:0]       r_env_lvl [2];
    logic [DLY_AW-1:0] r_ap_ptr [PTR_COUNT];
    logic [DLY_AW-1:0] r_haas_ptr;

    // datapath
    t_sample            r_x;
    t_sample            r_p;
    t_sample            r_d;
    t_sample            r_w;
    t_sample            r_a;
    t_sample            r_b;
    t_sample            r_out;
    logic [23:0]        r_mag;
    logic [23:0]        r_coef;
    logic [23:0]        r_env_cur;
    logic [23:0]        r_ms;
    logic [POS_W-1:0]   r_dly;
    logic [DLY_AW-1:0]  r_i1;
    logic [15:0]        r_frac;
    logic [6:0]         r_mix_m;
    logic [29:0]        r_num;
    logic               r_neg;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;

    logic                ap_we;
    logic [AP_AW-1:0]    ap_addr;
    t_sample             ap_wdata;
    logic [23:0]         ap_rdata;
    logic                hs_we;
    logic [DLY_AW-1:0]   hs_addr;
    t_sample             hs_wdata;
    logic [23:0]         hs_rdata;

    logic                   in_fire;
    logic                   out_fire;
    logic                   out_free;
    t_sample                in_x;
    logic [23:0]            in_mag;
    logic [23:0]            in_env;
    logic [STG_W-1:0]       in_last;
    logic [STG_W+1-1:0]     ptr_idx;
    logic [DLY_AW-1:0]      w_ptr;
    logic [POS_W-1:0]       w_pos;
    logic [DLY_AW-1:0]      w_i1;
    logic [55:0]            w_raw;
    logic [POS_W-1:0]       w_clamp;
    logic signed [63:0]     w_sum;
    logic signed [63:0]     w_env_sum;
    logic signed [63:0]     w_g;
    logic [63:0]            w_abs;
    logic [23:0]            w_q;
    logic signed [24:0]     w_y;
    t_sample                w_rd;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign in_x   = t_sample'(s_axis_tdata);
    assign in_mag = in_x[SAMPLE_BITS-1] ? 24'(-in_x) : 24'(in_x);
    assign in_env = r_env_lvl[s_axis_tuser[0]];
    assign in_last = (r_stage_count == 5'd0) ? '0 :
                     (r_stage_count > 5'(MAX_STAGES)) ? STG_W'(MAX_STAGES - 1) :
                     STG_W'(r_stage_count - 5'd1);

    assign ptr_idx = {r_ch, r_stage};
    assign w_ptr   = r_haas ? r_haas_ptr : r_ap_ptr[ptr_idx];
    assign w_pos   = {w_ptr, 16'd0} - r_dly;
    assign w_i1    = w_pos[POS_W-1:16];
    assign w_raw   = 56'(r_prod[63:8]);
    assign w_clamp = (w_raw < 56'(DLY_MIN)) ? DLY_MIN :
                     (w_raw > 56'(DLY_MAX)) ? DLY_MAX : POS_W'(w_raw);
    assign w_sum     = r_acc + r_prod;
    assign w_env_sum = w_sum + 64'sd8388608;
    assign w_g       = (r_prod + 64'sd32768) >>> 16;
    assign w_abs     = w_sum[63] ? 64'(-w_sum) : 64'(w_sum);
    assign w_q       = r_prod[MIX_SHIFT+23:MIX_SHIFT];
    assign w_y       = r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    assign w_rd      = r_haas ? t_sample'(hs_rdata) : t_sample'(ap_rdata);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_E1: begin
                mul_a = $signed(32'(r_coef));
                mul_b = $signed(32'(r_env_cur));
            end
            S_E2: begin
                mul_a = $signed(32'((25'd1 << 24) - 25'(r_coef)));
                mul_b = $signed(32'(r_mag));
            end
            S_B1: begin
                mul_a = $signed(32'(BASE_MS[r_stage]));
                mul_b = $signed(32'(r_env_cur));
            end
            S_D1: begin
                mul_a = $signed(32'(r_ms));
                mul_b = $signed(32'(r_samples_per_ms));
            end
            S_RD3: begin
                mul_a = 32'(r_a);
                mul_b = $signed(32'(17'h10000 - 17'(r_frac)));
            end
            S_I2: begin
                mul_a = 32'(r_b);
                mul_b = $signed(32'(r_frac));
            end
            S_A1: begin
                mul_a = $signed(GAIN_Q16);
                mul_b = 32'(r_d);
            end
            S_A2: begin
                mul_a = $signed(GAIN_Q16);
                mul_b = 32'(r_p);
            end
            S_H1: begin
                mul_a = $signed(32'(r_env_cur));
                mul_b = $signed(32'(r_shatter_ms));
            end
            S_M1: begin
                mul_a = 32'(r_x);
                mul_b = $signed(32'(MIX_FULL - r_mix_m));
            end
            S_M2: begin
                mul_a = 32'(r_p);
                mul_b = $signed(32'(r_mix_m));
            end
            S_M4, S_M5: begin
                mul_a = $signed(32'(r_num));
                mul_b = $signed(MIX_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        ap_we    = 1'b0;
        ap_addr  = {r_ch, r_stage, w_i1};
        ap_wdata = r_w;
        hs_we    = 1'b0;
        hs_addr  = w_i1;
        hs_wdata = r_p;
        case (r_state)
            S_CLR: begin
                ap_we    = 1'b1;
                ap_addr  = r_clr_cnt;
                ap_wdata = '0;
                hs_we    = 1'b1;
                hs_addr  = r_clr_cnt[DLY_AW-1:0];
                hs_wdata = '0;
            end
            S_RD2: begin
                ap_addr = {r_ch, r_stage, r_i1 + DLY_AW'(1)};
                hs_addr = r_i1 + DLY_AW'(1);
            end
            S_A3: begin
                ap_we   = 1'b1;
                ap_addr = {r_ch, r_stage, w_ptr};
            end
            S_H2: begin
                hs_we   = 1'b1;
                hs_addr = r_haas_ptr;
            end
            default: begin
                ap_we = 1'b0;
                hs_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  n_state = (r_clr_cnt == '1) ? S_IDLE : S_CLR;
            S_IDLE: n_state = in_fire ? S_E1 : S_IDLE;
            S_E1:   n_state = S_E2;
            S_E2:   n_state = S_E3;
            S_E3:   n_state = S_B1;
            S_B1:   n_state = S_B2;
            S_B2:   n_state = S_D1;
            S_D1:   n_state = S_D2;
            S_D2:   n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_I2;
            S_I2:   n_state = S_I3;
            S_I3:   n_state = r_haas ? S_M1 : S_A1;
            S_A1:   n_state = S_A2;
            S_A2:   n_state = S_A3;
            S_A3: begin
                if (r_stage != r_last) n_state = S_B1;
                else if (r_ch)         n_state = S_H1;
                else                   n_state = S_M1;
            end
            S_H1:   n_state = S_H2;
            S_H2:   n_state = S_D1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = out_free ? S_IDLE : S_M5;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLR;
            r_clr_cnt        <= '0;
            r_clr_done       <= 1'b0;
            r_stage          <= '0;
            r_last           <= '0;
            r_haas           <= 1'b0;
            r_ch             <= 1'b0;
            r_out_valid      <= 1'b0;
            r_haas_ptr       <= '0;
            r_env_lvl[0]     <= '0;
            r_env_lvl[1]     <= '0;
            for (int i = 0; i < PTR_COUNT; i++) begin
                r_ap_ptr[i] <= '0;
            end
            r_stage_count    <= 5'd4;
            r_attack_coeff   <= 24'd16431303;
            r_release_coeff  <= 24'd16770220;
            r_samples_per_ms <= 16'd12288;
            r_shatter_ms     <= 15'd2560;
            r_mix_percent    <= 7'd50;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STAGE_COUNT:    r_stage_count    <= i_cfg_data[4:0];
                    CFG_ATTACK_COEFF:   r_attack_coeff   <= i_cfg_data[23:0];
                    CFG_RELEASE_COEFF:  r_release_coeff  <= i_cfg_data[23:0];
                    CFG_SAMPLES_PER_MS: r_samples_per_ms <= i_cfg_data[15:0];
                    CFG_SHATTER_MS:     r_shatter_ms     <= i_cfg_data[14:0];
                    CFG_MIX_PERCENT:    r_mix_percent    <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + AP_AW'(1);
                if (r_clr_cnt == '1) r_clr_done <= 1'b1;
            end
            if (in_fire) begin
                r_ch    <= s_axis_tuser[0];
                r_stage <= '0;
                r_last  <= in_last;
                r_haas  <= 1'b0;
            end
            if (r_state == S_E3) begin
                r_env_lvl[r_ch] <= w_env_sum[47:24];
            end
            if (r_state == S_A3) begin
                r_ap_ptr[ptr_idx] <= w_ptr + DLY_AW'(1);
                if (r_stage != r_last) r_stage <= r_stage + STG_W'(1);
            end
            if (r_state == S_H2) begin
                r_haas_ptr <= r_haas_ptr + DLY_AW'(1);
                r_haas     <= 1'b1;
            end
            if (r_state == S_M5 && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                r_x       <= in_x;
                r_p       <= in_x;
                r_mag     <= in_mag;
                r_env_cur <= in_env;
                r_coef    <= (in_mag > in_env) ? r_attack_coeff : r_release_coeff;
                r_mix_m   <= (r_mix_percent > MIX_FULL) ? MIX_FULL : r_mix_percent;
            end
            S_E2:  r_acc <= r_prod;
            S_E3:  r_env_cur <= w_env_sum[47:24];
            S_B2:  r_ms <= 24'(BASE_MS[r_stage]) + 24'(r_prod[47:24]);
            S_D2:  r_dly <= w_clamp;
            S_RD1: begin
                r_i1   <= w_i1;
                r_frac <= w_pos[15:0];
            end
            S_RD2: r_a <= w_rd;
            S_RD3: r_b <= w_rd;
            S_I2:  r_acc <= r_prod;
            S_I3: begin
                if (r_haas) r_p <= t_sample'((w_sum + 64'sd32768) >>> 16);
                else        r_d <= t_sample'((w_sum + 64'sd32768) >>> 16);
            end
            S_A2:  r_w <= sat_sample(64'(r_p) + w_g);
            S_A3:  r_p <= sat_sample(64'(r_d) - w_g);
            S_H2:  r_ms <= 24'(r_prod[38:15]);
            S_M2:  r_acc <= r_prod;
            S_M3: begin
                r_neg <= w_sum[63];
                r_num <= 30'(w_abs + 64'd50);
            end
            S_M5: begin
                if (out_free) r_out <= sat_sample(64'(w_y));
            end
            default: ;
        endcase
    end

    emac_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (AP_DEPTH)
    ) u_ap_ram (
        .i_clk   (i_clk),
        .i_we    (ap_we),
        .i_addr  (ap_addr),
        .i_wdata (ap_wdata),
        .o_rdata (ap_rdata)
    );

    emac_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_haas_ram (
        .i_clk   (i_clk),
        .i_we    (hs_we),
        .i_addr  (hs_addr),
        .i_wdata (hs_wdata),
        .o_rdata (hs_rdata)
    );

    `EMAC_ASSERT_IMPL(a_ready_after_clear, s_axis_tready, r_clr_done, "input taken before clear")
    `EMAC_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "ready held after accept")
    `EMAC_ASSERT_IMPL(a_stage_bound, r_state != S_IDLE, r_stage <= r_last, "stage past last")
    `EMAC_ASSERT_IMPL(a_delay_bound, r_state == S_RD1, r_dly >= DLY_MIN && r_dly <= DLY_MAX, "delay out of range")

endmodule

// ===== verif/testbench.sv =====
// Testbench for envelope_modulated_allpass_chain: directed table, random phases, predictor.
`timescale 1ns / 1ps
module testbench;
    import emac_pkg::*;

    localparam int NUM_RANDOM = 830;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        bit                    ch;
        logic [23:0]           smp;
        bit                    typed;
        logic [23:0]           res;
    } t_row;

    localparam int NUM_ROWS = 30;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'h000000, 1'b1, 24'h000000},
        '{1'b1, CFG_MIX_PERCENT, 24'd0, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h800000, 1'b1, 24'h800000},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        '{1'b1, CFG_MIX_PERCENT, 24'd100, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b1, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h800000, 1'b0, 24'h0},
        '{1'b1, CFG_STAGE_COUNT, 24'd31, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'h555555, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'hAAAAAA, 1'b0, 24'h0},
        '{1'b1, CFG_SAMPLES_PER_MS, 24'd0, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h7FFFFF, 1'b0, 24'h0},
        '{1'b1, CFG_SAMPLES_PER_MS, 24'd65535, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b1, CFG_SHATTER_MS, 24'd32767, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h800000, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'h7FFFFF, 1'b0, 24'h0},
        '{1'b1, CFG_SHATTER_MS, 24'd0, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h123456, 1'b0, 24'h0},
        '{1'b1, CFG_MIX_PERCENT, 24'd127, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b1, CFG_ATTACK_COEFF, 24'd0, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b1, CFG_RELEASE_COEFF, 24'hFFFFFF, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h800000, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h000001, 1'b0, 24'h0},
        '{1'b1, CFG_ATTACK_COEFF, 24'hFFFFFF, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b1, CFG_RELEASE_COEFF, 24'd0, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b1, CFG_SHATTER_MS, 24'd25600, 1'b0, 24'h0, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b1, 24'h7FFFFF, 1'b0, 24'h0},
        '{1'b0, CFG_STAGE_COUNT, 24'd0, 1'b0, 24'h800000, 1'b0, 24'h0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    envelope_modulated_allpass_chain uut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state and registers
    logic [4:0]  stages_reg;
    logic [23:0] attack_reg;
    logic [23:0] release_reg;
    logic [15:0] spm_reg;
    logic [14:0] shatter_reg;
    logic [6:0]  mix_reg;
    longint      env_lvl [2];
    int          chain_mem [2 * MAX_STAGES * DELAY_DEPTH];
    int          chain_ptr [PTR_COUNT];
    int          haas_mem [DELAY_DEPTH];
    int          haas_ptr;

    logic [23:0] expected_q [$];
    int mismatches = 0;
    int checked = 0;
    int cfg_writes = 0;

    function automatic longint clip(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint ms_to_delay(longint ms_q16);
        longint d;
        d = (ms_q16 * longint'(spm_reg)) >>> 8;
        if (d < 64'sd65536) d = 64'sd65536;
        if (d > (longint'(DELAY_DEPTH - 1) <<< 16)) d = longint'(DELAY_DEPTH - 1) <<< 16;
        return d;
    endfunction

    function automatic longint tap_read(bit from_haas, int seg, int ptr, longint d);
        longint span;
        longint pos;
        longint f;
        int i1;
        int i2;
        longint a;
        longint b;
        span = longint'(DELAY_DEPTH) <<< 16;
        pos = (longint'(ptr) <<< 16) + span - d;
        if (pos >= span) pos -= span;
        i1 = int'(pos >>> 16);
        f = pos & 64'hFFFF;
        i2 = (i1 + 1 >= DELAY_DEPTH) ? 0 : i1 + 1;
        a = from_haas ? haas_mem[i1] : chain_mem[seg * DELAY_DEPTH + i1];
        b = from_haas ? haas_mem[i2] : chain_mem[seg * DELAY_DEPTH + i2];
        return round_shift(a * (64'sd65536 - f) + b * f, 16);
    endfunction

    function automatic void reset_model();
        stages_reg = 5'd4;
        attack_reg = 24'd16431303;
        release_reg = 24'd16770220;
        spm_reg = 16'd12288;
        shatter_reg = 15'd2560;
        mix_reg = 7'd50;
        env_lvl = '{0, 0};
        foreach (chain_mem[j]) chain_mem[j] = 0;
        foreach (chain_ptr[j]) chain_ptr[j] = 0;
        foreach (haas_mem[j]) haas_mem[j] = 0;
        haas_ptr = 0;
    endfunction

    function automatic void model_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_STAGE_COUNT:    stages_reg = v[4:0];
            CFG_ATTACK_COEFF:   attack_reg = v[23:0];
            CFG_RELEASE_COEFF:  release_reg = v[23:0];
            CFG_SAMPLES_PER_MS: spm_reg = v[15:0];
            CFG_SHATTER_MS:     shatter_reg = v[14:0];
            CFG_MIX_PERCENT:    mix_reg = v[6:0];
            default: ;
        endcase
    endfunction

    function automatic logic [23:0] mixed_sample(bit ch, logic [23:0] raw);
        longint x;
        longint mag;
        longint env;
        longint c;
        longint p;
        longint dl;
        longint w;
        longint base;
        longint ms;
        longint num;
        longint y;
        longint m;
        int n;
        int seg;
        int ptr;
        x = longint'(signed'(raw));
        mag = (x < 0) ? -x : x;
        env = env_lvl[ch];
        c = (mag > env) ? longint'(attack_reg) : longint'(release_reg);
        env = (c * env + ((64'sd1 <<< 24) - c) * mag + (64'sd1 <<< 23)) >>> 24;
        env_lvl[ch] = env;
        n = (stages_reg < 1) ? 1 : (stages_reg > MAX_STAGES) ? MAX_STAGES : int'(stages_reg);
        p = x;
        for (int i = 0; i < n; i++) begin
            seg = int'(ch) * MAX_STAGES + i;
            ptr = chain_ptr[seg];
            base = ((11 + 7 * i) * 64'sd65536 + 5) / 10;
            ms = base + ((base * env) >>> SAMPLE_BITS);
            dl = tap_read(1'b0, seg, ptr, ms_to_delay(ms));
            w = clip(p + round_shift(39322 * dl, 16));
            p = clip(dl - round_shift(39322 * p, 16));
            chain_mem[seg * DELAY_DEPTH + ptr] = int'(w);
            chain_ptr[seg] = (ptr + 1 >= DELAY_DEPTH) ? 0 : ptr + 1;
        end
        if (ch) begin
            ms = (env * longint'(shatter_reg)) >>> (SAMPLE_BITS - 9);
            haas_mem[haas_ptr] = int'(p);
            haas_ptr = (haas_ptr + 1 >= DELAY_DEPTH) ? 0 : haas_ptr + 1;
            p = tap_read(1'b1, 0, haas_ptr, ms_to_delay(ms));
        end
        m = (mix_reg > 100) ? 100 : longint'(mix_reg);
        num = x * (100 - m) + p * m;
        if (num >= 0) y = (num + 50) / 100;
        else y = -((-num + 50) / 100);
        return 24'(clip(y));
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // output side: random stalls
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                logic [23:0] want;
                want = expected_q.pop_front();
                checked++;
                if (m_axis_tdata !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample_out mismatch: expected %h got %h", want, m_axis_tdata);
                end
            end
        end
    end

    task automatic send_sample(bit ch, logic [23:0] smp, bit typed, logic [23:0] res);
        logic [23:0] pred;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tuser <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = mixed_sample(ch, smp);
        expected_q.push_back(typed ? res : pred);
    endtask

    task automatic hold_off(int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        hold_off(1);
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        model_cfg(idx, v);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF - 24'($urandom_range(0, 3));
            1: return 24'h800000 + 24'($urandom_range(0, 3));
            2: return 24'($urandom_range(0, 255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        #40ms;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].is_cfg) begin
                drain();
                write_reg(DIRECTED[r].idx, DIRECTED[r].val);
            end else begin
                send_sample(DIRECTED[r].ch, DIRECTED[r].smp, DIRECTED[r].typed, DIRECTED[r].res);
                hold_off(pick_gap());
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_reg(CFG_STAGE_COUNT, (ph == 3) ? 24'd16 : 24'($urandom_range(0, 31)));
            write_reg(CFG_ATTACK_COEFF, (ph == 1) ? 24'hFFFFFF : 24'($urandom));
            write_reg(CFG_RELEASE_COEFF, (ph == 2) ? 24'd0 : 24'($urandom));
            write_reg(CFG_SAMPLES_PER_MS, (ph == 4) ? 24'd65535 :
                      (ph == 5) ? 24'd0 : 24'($urandom_range(0, 65535)));
            write_reg(CFG_SHATTER_MS, (ph == 6) ? 24'd25600 : 24'($urandom_range(0, 32767)));
            write_reg(CFG_MIX_PERCENT, (ph == 7) ? 24'd100 : 24'($urandom_range(0, 127)));
            for (int k = 0; k < NUM_RANDOM / NUM_PHASES; k++) begin
                if ($urandom_range(0, 149) == 0) begin
                    hold_off(1);
                    while (expected_q.size() != 0) @(negedge i_clk);
                end
                send_sample(1'($urandom_range(0, 1)), random_sample(), 1'b0, 24'h0);
                hold_off(pick_gap());
            end
        end

        drain();
        repeat (250) @(posedge i_clk);
        $display("covered directed extremes and %0d register writes over %0d phases",
                 cfg_writes, NUM_PHASES);
        $display("%0d samples checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// ===== envelope_modulated_allpass_chain.f =====
+incdir+src
src/emac_pkg.sv
src/emac_ram.sv
src/envelope_modulated_allpass_chain.sv
verif/testbench.sv
